// ===== hw/rtl/led_pixel_spi_bit_encoder_assert.svh =====
// Assertion macros shared by the pixel encoder RTL.
`ifndef LED_PIXEL_SPI_BIT_ENCODER_ASSERT_SVH
`define LED_PIXEL_SPI_BIT_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LPSBE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LPSBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lpsbe_pkg.sv =====
// Types, constants and helpers for the LED pixel SPI bit encoder.
`timescale 1ns / 1ps
package lpsbe_pkg;

	localparam int BYTE_W        = 8;
	localparam int GAMMA_DEPTH   = 256;
	localparam int NUM_CH        = 4;
	localparam int BYTES_PER_CH  = 3;
	localparam int MAX_BYTES     = NUM_CH * BYTES_PER_CH;
	localparam int CNT_W         = $clog2(MAX_BYTES + 1);
	localparam int CFG_IDX_W     = 2;

	// Channel lanes
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_WHITE = 3;

	// Request operations
	localparam logic OP_GAMMA = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// Config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ORDER = 2'd1;

	// Color order codes
	localparam logic [3:0] ORD_RGB  = 4'd0;
	localparam logic [3:0] ORD_RBG  = 4'd1;
	localparam logic [3:0] ORD_GRB  = 4'd2;
	localparam logic [3:0] ORD_GBR  = 4'd3;
	localparam logic [3:0] ORD_BRG  = 4'd4;
	localparam logic [3:0] ORD_BGR  = 4'd5;
	localparam logic [3:0] ORD_RGBW = 4'd6;
	localparam logic [3:0] ORD_GRBW = 4'd7;

	localparam logic [BYTE_W-1:0] BRIGHTNESS_RST  = 8'hFF;
	localparam logic [3:0]        COLOR_ORDER_RST = ORD_GRB;

	typedef struct packed {
		logic              operation;
		logic [BYTE_W-1:0] gamma_index;
		logic [BYTE_W-1:0] gamma_value;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] white;
	} pixel_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] spi_byte;
		logic              last_of_pixel;
	} spi_rsp_t;

	// Each data bit becomes three line bits: 1 -> 110, 0 -> 100, MSB first.
	function automatic logic [3*BYTE_W-1:0] expand_byte(input logic [BYTE_W-1:0] v);
		logic [3*BYTE_W-1:0] bits;
		bits = '0;
		for (int k = 0; k < BYTE_W; k++) begin
			bits[3*k +: 3] = {1'b1, v[k], 1'b0};
		end
		return bits;
	endfunction

endpackage

// ===== hw/rtl/lpsbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lpsbe_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/led_pixel_spi_bit_encoder.sv =====
// Top level: LED pixel to 3x oversampled SPI byte encoder.
//
// Usage:
//   in channel  (in_valid/in_ready/in_req): one request per pixel or gamma load.
//     operation = OP_GAMMA writes gamma_value into gamma entry gamma_index and
//     yields no output. operation = OP_PIXEL scales each channel by brightness
//     ((v*brightness)>>8), maps it through the gamma table, orders the
//     channels per color_order and emits 3 SPI bytes per channel.
//   out channel (out_valid/out_ready/out_rsp): one SPI byte per transfer, MSB
//     first, last_of_pixel set on byte 9 (three channels) or 12 (RGBW/GRBW).
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//     only while idle. Index 0 brightness, 1 color_order, others ignored.
// Path: a pixel passes stage 1 and stage 2; its first byte shows once the serializer loads.
// Throughput: the output serializer sends one byte per cycle while out_ready is
//   high, 9 or 12 bytes per pixel; gamma loads emit no bytes. The pipeline
//   (multiply, gamma read, serializer) keeps taking requests while bytes drain.
// Reset: brightness 255, order GRB, gamma table reads as identity (per-entry
//   written flags are cleared), pipeline emptied. No clearing pass is needed.
// Stall: when out_ready is low the serializer holds its byte; the two stages
//   behind it fill, then in_ready drops. Nothing is lost or repeated.
`timescale 1ns / 1ps
`include "led_pixel_spi_bit_encoder_assert.svh"
module led_pixel_spi_bit_encoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  lpsbe_pkg::pixel_req_t               in_req,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lpsbe_pkg::spi_rsp_t                 out_rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lpsbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpsbe_pkg::BYTE_W-1:0]        cfg_data
);

	localparam int BW = lpsbe_pkg::BYTE_W;
	localparam int NC = lpsbe_pkg::NUM_CH;
	localparam int NB = lpsbe_pkg::MAX_BYTES;
	localparam int CW = lpsbe_pkg::CNT_W;

	// Config registers
	logic [BW-1:0] brightness_q;
	logic [3:0]    color_order_q;

	// Stage 1: scaled channels or gamma write
	logic                 v_s1;
	logic                 op_s1;
	logic [BW-1:0]        widx_s1;
	logic [BW-1:0]        wval_s1;
	logic [NC-1:0][BW-1:0] scl_s1;

	// Stage 2: gamma read results (pixels only)
	logic                  v_s2;
	logic [NC-1:0][BW-1:0] addr_s2;
	logic [NC-1:0]         set_s2;
	logic [NC-1:0][BW-1:0] gram_rd;

	// Written flags for the gamma table; unwritten entries read as identity
	logic [lpsbe_pkg::GAMMA_DEPTH-1:0] gamma_set_q;

	// Output serializer
	logic [NB-1:0][BW-1:0] ser_buf_q;
	logic [CW-1:0]         ser_cnt_q;

	logic                  s3_free, en1, en2, load3, gam_we, out_fire;
	logic [NC-1:0][2*BW-1:0] prod;
	logic [NC-1:0][BW-1:0]   shade;
	logic [NC-1:0][BW-1:0]   seq;
	logic                    four_ch;
	logic [NB-1:0][BW-1:0]   new_buf;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q  <= lpsbe_pkg::BRIGHTNESS_RST;
			color_order_q <= lpsbe_pkg::COLOR_ORDER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lpsbe_pkg::CFG_BRIGHTNESS:  brightness_q  <= cfg_data;
				lpsbe_pkg::CFG_COLOR_ORDER: color_order_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Pipeline control: a stage moves when the one ahead frees up
	assign out_fire = out_valid && out_ready;
	assign s3_free  = (ser_cnt_q == '0) || (out_ready && ser_cnt_q == CW'(1));
	assign en2      = !v_s2 || s3_free;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign load3    = v_s2 && s3_free;
	assign gam_we   = en2 && v_s1 && (op_s1 == lpsbe_pkg::OP_GAMMA);

	// Brightness scaling, one 8x8 multiply per lane into stage 1
	always_comb begin
		prod[lpsbe_pkg::CH_RED]   = in_req.red   * brightness_q;
		prod[lpsbe_pkg::CH_GREEN] = in_req.green * brightness_q;
		prod[lpsbe_pkg::CH_BLUE]  = in_req.blue  * brightness_q;
		prod[lpsbe_pkg::CH_WHITE] = in_req.white * brightness_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			op_s1   <= in_req.operation;
			widx_s1 <= in_req.gamma_index;
			wval_s1 <= in_req.gamma_value;
			for (int c = 0; c < NC; c++) begin
				scl_s1[c] <= prod[c][2*BW-1:BW];
			end
		end
	end

	// Stage 2: gamma table, one copy per lane so all four read at once
	for (genvar c = 0; c < NC; c++) begin : g_lane
		lpsbe_ram #(
			.DATA_W(BW),
			.DEPTH (lpsbe_pkg::GAMMA_DEPTH)
		) u_gamma (
			.clk  (clk),
			.we   (gam_we),
			.waddr(widx_s1),
			.wdata(wval_s1),
			.re   (en2),
			.raddr(scl_s1[c]),
			.rdata(gram_rd[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_set_q <= '0;
			v_s2        <= 1'b0;
		end else begin
			if (gam_we) begin
				gamma_set_q[widx_s1] <= 1'b1;
			end
			if (en2) begin
				v_s2 <= v_s1 && (op_s1 == lpsbe_pkg::OP_PIXEL);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int c = 0; c < NC; c++) begin
				addr_s2[c] <= scl_s1[c];
				set_s2[c]  <= gamma_set_q[scl_s1[c]];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			shade[c] = set_s2[c] ? gram_rd[c] : addr_s2[c];
		end
	end

	// Channel ordering
	always_comb begin
		seq     = '0;
		four_ch = 1'b0;
		case (color_order_q)
			lpsbe_pkg::ORD_RGB: begin
				seq[0] = shade[lpsbe_pkg::CH_RED];
				seq[1] = shade[lpsbe_pkg::CH_GREEN];
				seq[2] = shade[lpsbe_pkg::CH_BLUE];
			end
			lpsbe_pkg::ORD_RBG: begin
				seq[0] = shade[lpsbe_pkg::CH_RED];
				seq[1] = shade[lpsbe_pkg::CH_BLUE];
				seq[2] = shade[lpsbe_pkg::CH_GREEN];
			end
			lpsbe_pkg::ORD_GBR: begin
				seq[0] = shade[lpsbe_pkg::CH_GREEN];
				seq[1] = shade[lpsbe_pkg::CH_BLUE];
				seq[2] = shade[lpsbe_pkg::CH_RED];
			end
			lpsbe_pkg::ORD_BRG: begin
				seq[0] = shade[lpsbe_pkg::CH_BLUE];
				seq[1] = shade[lpsbe_pkg::CH_RED];
				seq[2] = shade[lpsbe_pkg::CH_GREEN];
			end
			lpsbe_pkg::ORD_BGR: begin
				seq[0] = shade[lpsbe_pkg::CH_BLUE];
				seq[1] = shade[lpsbe_pkg::CH_GREEN];
				seq[2] = shade[lpsbe_pkg::CH_RED];
			end
			lpsbe_pkg::ORD_RGBW: begin
				seq[0]  = shade[lpsbe_pkg::CH_RED];
				seq[1]  = shade[lpsbe_pkg::CH_GREEN];
				seq[2]  = shade[lpsbe_pkg::CH_BLUE];
				seq[3]  = shade[lpsbe_pkg::CH_WHITE];
				four_ch = 1'b1;
			end
			lpsbe_pkg::ORD_GRBW: begin
				seq[0]  = shade[lpsbe_pkg::CH_GREEN];
				seq[1]  = shade[lpsbe_pkg::CH_RED];
				seq[2]  = shade[lpsbe_pkg::CH_BLUE];
				seq[3]  = shade[lpsbe_pkg::CH_WHITE];
				four_ch = 1'b1;
			end
			default: begin
				// GRB, also for codes above the defined set
				seq[0] = shade[lpsbe_pkg::CH_GREEN];
				seq[1] = shade[lpsbe_pkg::CH_RED];
				seq[2] = shade[lpsbe_pkg::CH_BLUE];
			end
		endcase
	end

	// 24 line bits per channel, high byte first
	always_comb begin
		logic [3*BW-1:0] bits;
		for (int c = 0; c < NC; c++) begin
			bits = lpsbe_pkg::expand_byte(seq[c]);
			for (int s = 0; s < lpsbe_pkg::BYTES_PER_CH; s++) begin
				new_buf[c*lpsbe_pkg::BYTES_PER_CH + s] =
					bits[(lpsbe_pkg::BYTES_PER_CH-1-s)*BW +: BW];
			end
		end
	end

	// Stage 3: serializer, byte 0 is on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_cnt_q <= '0;
		end else if (load3) begin
			ser_cnt_q <= four_ch ? CW'(NC * lpsbe_pkg::BYTES_PER_CH)
			                     : CW'((NC - 1) * lpsbe_pkg::BYTES_PER_CH);
		end else if (out_fire) begin
			ser_cnt_q <= ser_cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load3) begin
			ser_buf_q <= new_buf;
		end else if (out_fire) begin
			for (int i = 0; i < NB - 1; i++) begin
				ser_buf_q[i] <= ser_buf_q[i+1];
			end
		end
	end

	assign out_valid             = (ser_cnt_q != '0);
	assign out_rsp.spi_byte      = ser_buf_q[0];
	assign out_rsp.last_of_pixel = (ser_cnt_q == CW'(1));

	// Checks
	`LPSBE_ASSERT_NEXT(a_load_count, load3,
		(ser_cnt_q == CW'(9) || ser_cnt_q == CW'(12)), "serializer loaded with bad count")
	`LPSBE_ASSERT_NOW(a_full_stall, (v_s1 && v_s2 && out_valid && !out_ready),
		!in_ready, "request taken while pipeline is full and stalled")
	`LPSBE_ASSERT_NEXT(a_gamma_flag, gam_we,
		gamma_set_q[$past(widx_s1)], "gamma write did not mark its entry")

endmodule

// ===== tb/tb_led_pixel_spi_bit_encoder.sv =====
// Testbench for the LED pixel SPI bit encoder: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps
module tb_led_pixel_spi_bit_encoder;

	// Run control
	localparam int CLK_HALF_NS  = 5;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_GAP    = 6;       // wait after the last owed byte, lets a gamma load settle
	localparam int END_GAP      = 20;
	localparam int HOLD_CYCLES  = 300;     // long receiver stall, fills the pipeline
	localparam int NUM_PHASES   = 3;
	localparam int NUM_BATCHES  = 5;
	localparam int BATCH_ITEMS  = 30;      // 3 x 5 x 30 = 450 random requests
	localparam longint TIMEOUT_NS = 64'd5_000_000;

	// Line code: each data bit goes out as three SPI bits
	localparam logic [2:0] LINE_ONE  = 3'b110;
	localparam logic [2:0] LINE_ZERO = 3'b100;

	// Indexes past the two real registers, which the block must ignore
	localparam logic [lpsbe_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [lpsbe_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	// Order codes past GRBW fall back to GRB
	localparam logic [3:0] ORD_FALLBACK_LO = 4'd8;
	localparam logic [3:0] ORD_FALLBACK_HI = 4'd15;

	// Line words for a channel byte of all zeros / all ones
	localparam logic [23:0] WORD_ZERO = 24'h924924;
	localparam logic [23:0] WORD_ONES = 24'hDB6DB6;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	lpsbe_pkg::pixel_req_t           in_req;
	logic                            out_valid;
	logic                            out_ready;
	lpsbe_pkg::spi_rsp_t             out_rsp;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [lpsbe_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lpsbe_pkg::BYTE_W-1:0]    cfg_data;

	led_pixel_spi_bit_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Shadow of the block state: registers and gamma table.
	// ------------------------------------------------------------------
	logic [7:0] bright_setting;
	logic [3:0] order_setting;
	logic [7:0] gamma_lut [lpsbe_pkg::GAMMA_DEPTH];

	// SPI bytes still owed by the block, oldest first
	lpsbe_pkg::spi_rsp_t spi_byte_queue [$];
	int                  mismatch_count;

	// Idle odds in percent per cycle, and the long-stall trigger
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;

	// ------------------------------------------------------------------
	// Directed stimulus table
	// ------------------------------------------------------------------
	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [lpsbe_pkg::CFG_IDX_W-1:0] reg_index;
		logic [7:0]                      reg_data;
		lpsbe_pkg::pixel_req_t           req;
		int                              known_channels;  // 0: predicted, else typed
		logic [23:0]                     known_word;      // line word on every channel
	} stim_row_t;

	stim_row_t directed_rows [$];

	function automatic void add_cfg(input logic [lpsbe_pkg::CFG_IDX_W-1:0] idx,
			input logic [7:0] data);
		stim_row_t row;
		row = '{kind: ROW_CFG, default: '0};
		row.reg_index = idx;
		row.reg_data = data;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_pixel(input logic [7:0] r, g, b, w,
			input int nch, input logic [23:0] word);
		stim_row_t row;
		row = '{kind: ROW_REQ, default: '0};
		row.req.operation = lpsbe_pkg::OP_PIXEL;
		row.req.gamma_index = ~r;      // junk, must be ignored on a pixel
		row.req.gamma_value = g ^ b;
		row.req.red = r;
		row.req.green = g;
		row.req.blue = b;
		row.req.white = w;
		row.known_channels = nch;
		row.known_word = word;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_gamma(input logic [7:0] idx, input logic [7:0] val);
		stim_row_t row;
		row = '{kind: ROW_REQ, default: '0};
		row.req.operation = lpsbe_pkg::OP_GAMMA;
		row.req.gamma_index = idx;
		row.req.gamma_value = val;
		row.req.red = 8'hFF;           // junk pixel fields, must be ignored
		row.req.green = 8'h00;
		row.req.blue = 8'h5A;
		row.req.white = 8'hA5;
		directed_rows.push_back(row);
	endfunction

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic logic [23:0] line_word(input logic [7:0] v);
		logic [23:0] bits;
		bits = '0;
		for (int k = 7; k >= 0; k--)
			bits = {bits[20:0], (v[k] ? LINE_ONE : LINE_ZERO)};
		return bits;
	endfunction

	// brightness scale, then gamma lookup
	function automatic logic [7:0] shade_channel(input logic [7:0] v);
		logic [15:0] prod;
		prod = v * bright_setting;
		return gamma_lut[prod[15:8]];
	endfunction

	// Three SPI bytes of one channel, high byte first
	function automatic void queue_channel(input logic [23:0] word, input bit last_ch);
		lpsbe_pkg::spi_rsp_t rsp;
		for (int s = 2; s >= 0; s--) begin
			rsp.spi_byte = word[s*8 +: 8];
			rsp.last_of_pixel = last_ch && (s == 0);
			spi_byte_queue.push_back(rsp);
		end
	endfunction

	// Apply one accepted request to the shadow state and queue its bytes
	function automatic void apply_request(input lpsbe_pkg::pixel_req_t req);
		logic [7:0] r, g, b, w;
		logic [7:0] seq [4];
		int nch;
		if (req.operation == lpsbe_pkg::OP_GAMMA) begin
			gamma_lut[req.gamma_index] = req.gamma_value;
			return;
		end
		r = shade_channel(req.red);
		g = shade_channel(req.green);
		b = shade_channel(req.blue);
		w = shade_channel(req.white);
		nch = 3;
		seq[3] = w;
		case (order_setting)
			lpsbe_pkg::ORD_RGB:  begin seq[0] = r; seq[1] = g; seq[2] = b; end
			lpsbe_pkg::ORD_RBG:  begin seq[0] = r; seq[1] = b; seq[2] = g; end
			lpsbe_pkg::ORD_GBR:  begin seq[0] = g; seq[1] = b; seq[2] = r; end
			lpsbe_pkg::ORD_BRG:  begin seq[0] = b; seq[1] = r; seq[2] = g; end
			lpsbe_pkg::ORD_BGR:  begin seq[0] = b; seq[1] = g; seq[2] = r; end
			lpsbe_pkg::ORD_RGBW: begin seq[0] = r; seq[1] = g; seq[2] = b; nch = 4; end
			lpsbe_pkg::ORD_GRBW: begin seq[0] = g; seq[1] = r; seq[2] = b; nch = 4; end
			default:  begin seq[0] = g; seq[1] = r; seq[2] = b; end  // GRB and fallback
		endcase
		for (int c = 0; c < nch; c++)
			queue_channel(line_word(seq[c]), c == nch - 1);
	endfunction

	// ------------------------------------------------------------------
	// Request and register drivers: change at negedge, sample at posedge.
	// ------------------------------------------------------------------
	task automatic send_request(input lpsbe_pkg::pixel_req_t req);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			in_req <= lpsbe_pkg::pixel_req_t'({$urandom, $urandom});  // junk while idle
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_req <= req;
		do @(posedge clk); while (!in_ready);
		apply_request(req);
	endtask

	task automatic release_in();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Wait until every owed byte is out, then let a gamma load settle
	task automatic drain();
		release_in();
		while (spi_byte_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// Registers are only written with the block idle
	task automatic write_reg(input logic [lpsbe_pkg::CFG_IDX_W-1:0] idx,
			input logic [7:0] data);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lpsbe_pkg::CFG_BRIGHTNESS:  bright_setting = data;
			lpsbe_pkg::CFG_COLOR_ORDER: order_setting = data[3:0];
			default: ;   // spare indexes write nothing
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_brightness();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Clock, timeout
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAIL led_pixel_spi_bit_encoder");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: random out_ready at negedge; one long hold-off on request.
	// ------------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_off = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Scoreboard: every accepted byte against the oldest owed one
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		lpsbe_pkg::spi_rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (spi_byte_queue.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected byte, got spi_byte=%02h last_of_pixel=%0b",
					$realtime, out_rsp.spi_byte, out_rsp.last_of_pixel);
			end else begin
				want = spi_byte_queue.pop_front();
				if (out_rsp.spi_byte !== want.spi_byte) begin
					mismatch_count++;
					$display("%0t: spi_byte expected %02h got %02h",
						$realtime, want.spi_byte, out_rsp.spi_byte);
				end
				if (out_rsp.last_of_pixel !== want.last_of_pixel) begin
					mismatch_count++;
					$display("%0t: last_of_pixel expected %0b got %0b",
						$realtime, want.last_of_pixel, out_rsp.last_of_pixel);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		lpsbe_pkg::pixel_req_t req;
		stim_row_t             row;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatch_count = 0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// reset values of the shadow
		bright_setting = lpsbe_pkg::BRIGHTNESS_RST;
		order_setting = lpsbe_pkg::COLOR_ORDER_RST;
		for (int i = 0; i < lpsbe_pkg::GAMMA_DEPTH; i++)
			gamma_lut[i] = 8'(i);

		// Directed table. Typed rows are the ones whose channels all shade to
		// zero or to 0xFF, so the line word is obvious.
		add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 3, WORD_ZERO);  // straight after reset, GRB
		add_pixel(8'hFF, 8'h00, 8'hAA, 8'h55, 0, '0);         // white dropped on 3 channels
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, '0);         // full scale, 255*255>>8
		add_gamma(8'hFF, 8'h00);                              // top entry
		add_gamma(8'h00, 8'hFF);                              // zero maps to full
		add_pixel(8'hFF, 8'h01, 8'h80, 8'h7F, 0, '0);
		add_cfg(lpsbe_pkg::CFG_BRIGHTNESS, 8'h00);
		add_pixel(8'h12, 8'h34, 8'h56, 8'h78, 3, WORD_ONES);  // brightness 0 -> gamma[0]
		add_cfg(lpsbe_pkg::CFG_COLOR_ORDER, {4'h0, lpsbe_pkg::ORD_RGBW});
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 4, WORD_ONES);  // four channels
		add_cfg(lpsbe_pkg::CFG_BRIGHTNESS, 8'h80);
		add_cfg(lpsbe_pkg::CFG_COLOR_ORDER, {4'h0, lpsbe_pkg::ORD_GRBW});
		add_pixel(8'hFF, 8'h80, 8'h01, 8'h7F, 0, '0);
		add_cfg(lpsbe_pkg::CFG_COLOR_ORDER, {4'h0, lpsbe_pkg::ORD_RGB});
		add_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C, 0, '0);
		add_cfg(lpsbe_pkg::CFG_COLOR_ORDER, {4'h0, lpsbe_pkg::ORD_RBG});
		add_pixel(8'hF0, 8'h0F, 8'h99, 8'h66, 0, '0);
		add_cfg(lpsbe_pkg::CFG_COLOR_ORDER, {4'h0, lpsbe_pkg::ORD_GBR});
		add_pixel(8'hE1, 8'h1E, 8'hB4, 8'h4B, 0, '0);
		add_cfg(lpsbe_pkg::CFG_COLOR_ORDER, {4'h0, lpsbe_pkg::ORD_BRG});
		add_pixel(8'hFE, 8'h02, 8'hC0, 8'h40, 0, '0);
		add_cfg(lpsbe_pkg::CFG_COLOR_ORDER, {4'h0, lpsbe_pkg::ORD_BGR});
		add_pixel(8'h81, 8'h7E, 8'hFF, 8'h00, 0, '0);
		add_cfg(lpsbe_pkg::CFG_COLOR_ORDER, {4'hF, ORD_FALLBACK_LO});  // upper bits drop
		add_pixel(8'hDE, 8'hAD, 8'hBE, 8'hEF, 0, '0);
		add_cfg(lpsbe_pkg::CFG_COLOR_ORDER, {4'h0, ORD_FALLBACK_HI});
		add_pixel(8'hCA, 8'hFE, 8'hBA, 8'hBE, 0, '0);
		add_cfg(CFG_SPARE_2, 8'hFF);                           // ignored
		add_cfg(CFG_SPARE_3, 8'h00);                           // ignored
		add_pixel(8'h11, 8'hEE, 8'h77, 8'h88, 0, '0);
		add_cfg(lpsbe_pkg::CFG_BRIGHTNESS, 8'h01);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3, WORD_ONES);  // 255*1>>8 = 0
		add_gamma(8'h00, 8'h00);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3, WORD_ZERO);
		add_cfg(lpsbe_pkg::CFG_BRIGHTNESS, 8'hFF);
		add_cfg(lpsbe_pkg::CFG_COLOR_ORDER, {4'h0, lpsbe_pkg::ORD_RGBW});
		add_gamma(8'h7F, 8'hAB);
		add_pixel(8'h80, 8'h80, 8'h80, 8'h80, 0, '0);          // 128*255>>8 = 127

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, moderate idling on both sides
		send_idle_pct = 9;
		recv_idle_pct = 20;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CFG) begin
				write_reg(row.reg_index, row.reg_data);
			end else if (row.known_channels == 0 ||
					row.req.operation == lpsbe_pkg::OP_GAMMA) begin
				send_request(row.req);
			end else begin
				// typed expectation: queue it, then send without predicting
				for (int c = 0; c < row.known_channels; c++)
					queue_channel(row.known_word, c == row.known_channels - 1);
				@(negedge clk);
				in_valid <= 1'b1;
				in_req <= row.req;
				do @(posedge clk); while (!in_ready);
			end
		end

		// Random part: three idling phases, several register settings each
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin send_idle_pct = 9;  recv_idle_pct = 85; end
				1: begin send_idle_pct = 85; recv_idle_pct = 9;  end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int b = 0; b < NUM_BATCHES; b++) begin
				write_reg(lpsbe_pkg::CFG_BRIGHTNESS, pick_brightness());
				write_reg(lpsbe_pkg::CFG_COLOR_ORDER, 8'($urandom));
				if ($urandom_range(3) == 0)
					write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, 8'($urandom));
				// back-pressure test: receiver stalls while requests keep coming
				if (p == NUM_PHASES - 1 && b == 0)
					hold_off = 1'b1;
				for (int n = 0; n < BATCH_ITEMS; n++) begin
					req.operation = ($urandom_range(4) == 0) ? lpsbe_pkg::OP_GAMMA
					                                         : lpsbe_pkg::OP_PIXEL;
					req.gamma_index = pick_byte();
					req.gamma_value = pick_byte();
					req.red = pick_byte();
					req.green = pick_byte();
					req.blue = pick_byte();
					req.white = pick_byte();
					send_request(req);
				end
			end
		end

		release_in();
		while (spi_byte_queue.size() != 0) @(posedge clk);
		repeat (END_GAP) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS led_pixel_spi_bit_encoder");
		else
			$display("FAIL led_pixel_spi_bit_encoder");
		$finish;
	end

endmodule
